/* rtl/bilinear_integer_upscaler_defines.svh */
// Assertion macros for the checker file.
`ifndef BILINEAR_INTEGER_UPSCALER_DEFINES_SVH
`define BILINEAR_INTEGER_UPSCALER_DEFINES_SVH

// Checked at every clock edge outside reset.
`define BIU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define BIU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/biu_pkg.sv */
`default_nettype none
package biu_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int VALUE_BITS  = 24;
    localparam int COORD_BITS  = 13;
    localparam int FACTOR_BITS = 4;
    localparam int DIM_BITS    = 11;
    localparam int CNT_BITS    = 10;
    localparam int MAX_COLS    = 1024;
    localparam int ROW_LIMIT   = 1024;
    localparam int MAX_FACTOR  = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_FACTOR    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_ROWS = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_COLS = 2'd2;

    typedef struct packed {
        logic [FACTOR_BITS-1:0] factor;
        logic [DIM_BITS-1:0]    rows;
        logic [DIM_BITS-1:0]    cols;
    } t_cfg;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] x;
        logic signed [SAMPLE_BITS-1:0] up;
        logic signed [SAMPLE_BITS-1:0] ul;
        logic signed [SAMPLE_BITS-1:0] lf;
        logic [CNT_BITS-1:0]           row;
        logic [CNT_BITS-1:0]           col;
    } t_entry;

    // Divide by 2*F*F as a shift, then a multiply by the reciprocal of the odd part.
    typedef struct packed {
        logic [2:0]  shift;
        logic [5:0]  odd;
        logic [31:0] mult;
        logic [5:0]  rsh;
    } t_div;

    function automatic t_div div_params(input logic [FACTOR_BITS-1:0] f);
        t_div d;
        case (f)
            4'd2:    d = '{3'd3, 6'd1, 32'h8000_0000, 6'd31};
            4'd3:    d = '{3'd1, 6'd9, 32'd3817748707, 6'd35};
            4'd4:    d = '{3'd5, 6'd1, 32'h8000_0000, 6'd31};
            4'd5:    d = '{3'd1, 6'd25, 32'd2748779069, 6'd36};
            4'd6:    d = '{3'd3, 6'd9, 32'd3817748707, 6'd35};
            4'd7:    d = '{3'd1, 6'd49, 32'd2804876601, 6'd37};
            4'd8:    d = '{3'd7, 6'd1, 32'h8000_0000, 6'd31};
            default: d = '{3'd1, 6'd1, 32'h8000_0000, 6'd31};
        endcase
        return d;
    endfunction

    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                      input logic [DIM_BITS-1:0] hi);
        logic [DIM_BITS-1:0] r;
        if (v == '0) begin
            r = DIM_BITS'(1);
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [FACTOR_BITS-1:0] clamp_factor(input logic [FACTOR_BITS-1:0] v);
        logic [FACTOR_BITS-1:0] r;
        if (v == '0) begin
            r = FACTOR_BITS'(1);
        end else if (v > FACTOR_BITS'(MAX_FACTOR)) begin
            r = FACTOR_BITS'(MAX_FACTOR);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/bilinear_integer_upscaler.sv */
// Channel   Valid         Ready         Payload
// input     i_in_valid    o_in_ready    i_sample
// output    o_out_valid   i_out_ready   o_value, o_out_row, o_out_col, o_last_of_run
// config    i_cfg_we      (none)        i_cfg_index, i_cfg_data
//
// Each sample yields 1 to F*F points, issued one per cycle while the output is not
// stalled, by the point iterator of the back part.
// Points pass weight, product, magnitude, multiply, quotient and output registers.
// Reset is synchronous; the line store is not cleared and needs none.
// A stalled output freezes the arithmetic pipeline; a four-item queue lets the
// front keep taking samples meanwhile.
`default_nettype none
module bilinear_integer_upscaler (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic signed [biu_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic signed [biu_pkg::VALUE_BITS-1:0]       o_value,
    output logic [biu_pkg::COORD_BITS-1:0]              o_out_row,
    output logic [biu_pkg::COORD_BITS-1:0]              o_out_col,
    output logic                                        o_last_of_run,
    input  wire logic                                   i_cfg_we,
    input  wire logic [biu_pkg::CFG_IDX_BITS-1:0]       i_cfg_index,
    input  wire logic [biu_pkg::DIM_BITS-1:0]           i_cfg_data
);

    logic [biu_pkg::FACTOR_BITS-1:0] r_factor;
    logic [biu_pkg::DIM_BITS-1:0]    r_rows;
    logic [biu_pkg::DIM_BITS-1:0]    r_cols;
    logic                            restart;
    biu_pkg::t_cfg                   cfg;
    logic                            push;
    logic                            full;
    logic                            pop;
    logic                            q_valid;
    biu_pkg::t_entry                 push_entry;
    biu_pkg::t_entry                 head_entry;

    assign restart = i_cfg_we && (i_cfg_index == biu_pkg::REG_FACTOR
                               || i_cfg_index == biu_pkg::REG_GRID_ROWS
                               || i_cfg_index == biu_pkg::REG_GRID_COLS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= biu_pkg::FACTOR_BITS'(2);
            r_rows   <= biu_pkg::DIM_BITS'(3);
            r_cols   <= biu_pkg::DIM_BITS'(3);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                biu_pkg::REG_FACTOR:    r_factor <= i_cfg_data[biu_pkg::FACTOR_BITS-1:0];
                biu_pkg::REG_GRID_ROWS: r_rows   <= i_cfg_data;
                biu_pkg::REG_GRID_COLS: r_cols   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg.factor = biu_pkg::clamp_factor(r_factor);
        cfg.rows   = biu_pkg::clamp_dim(r_rows, biu_pkg::DIM_BITS'(biu_pkg::ROW_LIMIT));
        cfg.cols   = biu_pkg::clamp_dim(r_cols, biu_pkg::DIM_BITS'(biu_pkg::MAX_COLS));
    end

    biu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_restart  (restart),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sample   (i_sample),
        .i_full     (full),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    biu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    biu_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_factor      (cfg.factor),
        .i_q_valid     (q_valid),
        .i_q_entry     (head_entry),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_value       (o_value),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_last_of_run (o_last_of_run)
    );

endmodule
`default_nettype wire

/* rtl/biu_front.sv */
`default_nettype none
module biu_front (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire biu_pkg::t_cfg                        i_cfg,
    input  wire logic                                 i_restart,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic signed [biu_pkg::SAMPLE_BITS-1:0] i_sample,
    input  wire logic                                 i_full,
    output logic                                      o_push,
    output biu_pkg::t_entry                           o_entry
);

    logic signed [biu_pkg::SAMPLE_BITS-1:0] r_store [biu_pkg::MAX_COLS];
    logic signed [biu_pkg::SAMPLE_BITS-1:0] r_rd;
    logic signed [biu_pkg::SAMPLE_BITS-1:0] r_x;
    logic signed [biu_pkg::SAMPLE_BITS-1:0] r_left;
    logic signed [biu_pkg::SAMPLE_BITS-1:0] r_up_left;
    logic [biu_pkg::CNT_BITS-1:0]           r_row;
    logic [biu_pkg::CNT_BITS-1:0]           r_col;
    logic [biu_pkg::CNT_BITS-1:0]           r_row_cnt;
    logic [biu_pkg::CNT_BITS-1:0]           r_col_cnt;
    logic                                   r_a_valid;
    logic                                   accept;
    logic [biu_pkg::DIM_BITS-1:0]           col_next;
    logic [biu_pkg::DIM_BITS-1:0]           row_next;

    assign o_in_ready = !r_a_valid || !i_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = r_a_valid && !i_full;
    assign col_next   = biu_pkg::DIM_BITS'(r_col_cnt) + biu_pkg::DIM_BITS'(1);
    assign row_next   = biu_pkg::DIM_BITS'(r_row_cnt) + biu_pkg::DIM_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd               <= r_store[r_col_cnt];
            r_store[r_col_cnt] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x   <= i_sample;
            r_row <= r_row_cnt;
            r_col <= r_col_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_row_cnt <= '0;
            r_col_cnt <= '0;
            r_left    <= '0;
            r_up_left <= '0;
        end else begin
            if (accept) begin
                r_a_valid <= 1'b1;
            end else if (o_push) begin
                r_a_valid <= 1'b0;
            end
            if (o_push) begin
                r_up_left <= r_rd;
                r_left    <= r_x;
            end
            if (i_restart) begin
                r_row_cnt <= '0;
                r_col_cnt <= '0;
            end else if (accept) begin
                if (col_next >= i_cfg.cols) begin
                    r_col_cnt <= '0;
                    if (row_next >= i_cfg.rows) begin
                        r_row_cnt <= '0;
                    end else begin
                        r_row_cnt <= row_next[biu_pkg::CNT_BITS-1:0];
                    end
                end else begin
                    r_col_cnt <= col_next[biu_pkg::CNT_BITS-1:0];
                end
            end
        end
    end

    // Corners outside the grid carry zero weight; they are zeroed so unwritten
    // line store entries never reach the arithmetic.
    always_comb begin
        o_entry.x   = r_x;
        o_entry.up  = (r_row == '0) ? '0 : r_rd;
        o_entry.ul  = (r_row == '0 || r_col == '0) ? '0 : r_up_left;
        o_entry.lf  = (r_col == '0) ? '0 : r_left;
        o_entry.row = r_row;
        o_entry.col = r_col;
    end

endmodule
`default_nettype wire

/* rtl/biu_queue.sv */
`default_nettype none
module biu_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire biu_pkg::t_entry i_entry,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output biu_pkg::t_entry      o_entry
);

    biu_pkg::t_entry              r_mem [biu_pkg::QUEUE_DEPTH];
    logic [biu_pkg::QPTR_BITS-1:0] r_wp;
    logic [biu_pkg::QPTR_BITS-1:0] r_rp;
    logic [biu_pkg::QPTR_BITS:0]   r_cnt;

    assign o_full  = (r_cnt == (biu_pkg::QPTR_BITS+1)'(biu_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_entry = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + biu_pkg::QPTR_BITS'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + biu_pkg::QPTR_BITS'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (biu_pkg::QPTR_BITS+1)'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - (biu_pkg::QPTR_BITS+1)'(1);
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/biu_back.sv */
`default_nettype none
module biu_back (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic [biu_pkg::FACTOR_BITS-1:0]      i_factor,
    input  wire logic                                 i_q_valid,
    input  wire biu_pkg::t_entry                      i_q_entry,
    output logic                                      o_pop,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic signed [biu_pkg::VALUE_BITS-1:0]     o_value,
    output logic [biu_pkg::COORD_BITS-1:0]            o_out_row,
    output logic [biu_pkg::COORD_BITS-1:0]            o_out_col,
    output logic                                      o_last_of_run
);

    typedef struct packed {
        logic [biu_pkg::COORD_BITS-1:0] row;
        logic [biu_pkg::COORD_BITS-1:0] col;
        logic                           last;
    } t_tag;

    localparam int W_BITS = 7;
    localparam int P_BITS = biu_pkg::SAMPLE_BITS + W_BITS + 1;
    localparam int S_BITS = P_BITS + 2;
    localparam int N_BITS = 36;
    localparam int M_BITS = 30;
    localparam int X_BITS = M_BITS + 32;
    localparam int Q_BITS = 25;
    localparam int R_BITS = 31;

    logic [biu_pkg::FACTOR_BITS-1:0] f;
    biu_pkg::t_div                   dv;
    logic [W_BITS-1:0]               f2;

    logic                            en;
    logic                            issue;
    logic                            last_pt;
    logic                            r_it_valid;
    biu_pkg::t_entry                 r_ent;
    logic [biu_pkg::FACTOR_BITS-1:0] r_a;
    logic [biu_pkg::FACTOR_BITS-1:0] r_b;
    logic [biu_pkg::FACTOR_BITS-1:0] b_first;

    logic                            r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    t_tag                            r_t1, r_t2, r_t3, r_t4, r_t5;
    t_tag                            n_t1;

    logic [W_BITS-1:0]                      r_w_ul, r_w_u, r_w_l, r_w_x;
    logic signed [biu_pkg::SAMPLE_BITS-1:0] r_s_ul, r_s_u, r_s_l, r_s_x;
    logic [biu_pkg::FACTOR_BITS-1:0]        fa, fb;

    logic signed [P_BITS-1:0] r_p_ul, r_p_u, r_p_l, r_p_x;

    logic signed [S_BITS-1:0] sum;
    logic signed [N_BITS-1:0] num;
    logic [N_BITS-1:0]        mag;
    logic [M_BITS-1:0]        r_m3, r_m4, r_m5;
    logic                     r_neg3, r_neg4, r_neg5;

    logic [X_BITS-1:0] r_prod;
    logic [X_BITS-1:0] shifted;
    logic [Q_BITS-1:0] r_qe;

    logic [R_BITS-1:0] rem;
    logic [Q_BITS-1:0] q_fix;
    logic [Q_BITS-1:0] q_sgn;
    logic [biu_pkg::COORD_BITS-1:0] row_base;
    logic [biu_pkg::COORD_BITS-1:0] col_base;

    assign f       = i_factor;
    assign dv      = biu_pkg::div_params(f);
    assign f2      = W_BITS'(f * f);
    assign en      = !r_v6 || i_out_ready;
    assign issue   = r_it_valid && en;
    assign last_pt = (r_a == f) && (r_b == f);
    assign o_pop   = i_q_valid && (!r_it_valid || (issue && last_pt));
    assign b_first = (r_ent.col == '0) ? f : biu_pkg::FACTOR_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_it_valid <= 1'b0;
        end else if (o_pop) begin
            r_it_valid <= 1'b1;
            r_ent      <= i_q_entry;
            r_a        <= (i_q_entry.row == '0) ? f : biu_pkg::FACTOR_BITS'(1);
            r_b        <= (i_q_entry.col == '0) ? f : biu_pkg::FACTOR_BITS'(1);
        end else if (issue) begin
            if (last_pt) begin
                r_it_valid <= 1'b0;
            end else if (r_b == f) begin
                r_a <= r_a + biu_pkg::FACTOR_BITS'(1);
                r_b <= b_first;
            end else begin
                r_b <= r_b + biu_pkg::FACTOR_BITS'(1);
            end
        end
    end

    always_comb begin
        fa       = f - r_a;
        fb       = f - r_b;
        row_base = biu_pkg::COORD_BITS'(r_ent.row) * biu_pkg::COORD_BITS'(f);
        col_base = biu_pkg::COORD_BITS'(r_ent.col) * biu_pkg::COORD_BITS'(f);
        n_t1.row  = row_base + biu_pkg::COORD_BITS'(r_a) - biu_pkg::COORD_BITS'(f);
        n_t1.col  = col_base + biu_pkg::COORD_BITS'(r_b) - biu_pkg::COORD_BITS'(f);
        n_t1.last = last_pt;
    end

    always_comb begin
        sum = S_BITS'(r_p_ul) + S_BITS'(r_p_u) + S_BITS'(r_p_l) + S_BITS'(r_p_x);
        num = (N_BITS'(sum) <<< 9) + N_BITS'(f2);
        if (num[N_BITS-1]) begin
            mag = N_BITS'(-num) + N_BITS'({f2, 1'b0}) - N_BITS'(1);
        end else begin
            mag = N_BITS'(num);
        end
    end

    assign shifted = r_prod >> dv.rsh;
    assign rem     = R_BITS'(r_m5) - R_BITS'(r_qe) * R_BITS'(dv.odd);
    assign q_fix   = (rem >= R_BITS'(dv.odd)) ? r_qe + Q_BITS'(1) : r_qe;
    assign q_sgn   = r_neg5 ? -q_fix : q_fix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (en) begin
            r_v1 <= issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t1   <= n_t1;
            r_w_ul <= W_BITS'(fa * fb);
            r_w_u  <= W_BITS'(fa * r_b);
            r_w_l  <= W_BITS'(r_a * fb);
            r_w_x  <= W_BITS'(r_a * r_b);
            r_s_ul <= r_ent.ul;
            r_s_u  <= r_ent.up;
            r_s_l  <= r_ent.lf;
            r_s_x  <= r_ent.x;

            r_t2   <= r_t1;
            r_p_ul <= P_BITS'($signed({1'b0, r_w_ul})) * P_BITS'(r_s_ul);
            r_p_u  <= P_BITS'($signed({1'b0, r_w_u}))  * P_BITS'(r_s_u);
            r_p_l  <= P_BITS'($signed({1'b0, r_w_l}))  * P_BITS'(r_s_l);
            r_p_x  <= P_BITS'($signed({1'b0, r_w_x}))  * P_BITS'(r_s_x);

            r_t3   <= r_t2;
            r_neg3 <= num[N_BITS-1];
            r_m3   <= M_BITS'(mag >> dv.shift);

            r_t4   <= r_t3;
            r_neg4 <= r_neg3;
            r_m4   <= r_m3;
            r_prod <= X_BITS'(r_m3) * X_BITS'(dv.mult);

            r_t5   <= r_t4;
            r_neg5 <= r_neg4;
            r_m5   <= r_m4;
            r_qe   <= shifted[Q_BITS-1:0];

            o_value       <= q_sgn[biu_pkg::VALUE_BITS-1:0];
            o_out_row     <= r_t5.row;
            o_out_col     <= r_t5.col;
            o_last_of_run <= r_t5.last;
        end
    end

    assign o_out_valid = r_v6;

endmodule
`default_nettype wire

/* rtl/biu_checker.sv */
`default_nettype none
`include "bilinear_integer_upscaler_defines.svh"
module biu_checker (
    input wire logic                                   i_clk,
    input wire logic                                   i_rst_n,
    input wire logic                                   i_in_valid,
    input wire logic                                   o_in_ready,
    input wire logic signed [biu_pkg::SAMPLE_BITS-1:0] i_sample,
    input wire logic                                   o_out_valid,
    input wire logic                                   i_out_ready,
    input wire logic signed [biu_pkg::VALUE_BITS-1:0]  o_value,
    input wire logic [biu_pkg::COORD_BITS-1:0]         o_out_row,
    input wire logic [biu_pkg::COORD_BITS-1:0]         o_out_col,
    input wire logic                                   o_last_of_run,
    input wire logic                                   i_cfg_we,
    input wire logic [biu_pkg::CFG_IDX_BITS-1:0]       i_cfg_index,
    input wire logic [biu_pkg::DIM_BITS-1:0]           i_cfg_data
);

    // Points of one run leave back to back once the output moves.
    `BIU_ASSERT(a_run_unbroken, (o_out_valid && i_out_ready && !o_last_of_run |=> o_out_valid), "run of points broken")

    `BIU_ASSERT(a_coord_range, (o_out_valid |-> (o_out_row <= 13'd8184) && (o_out_col <= 13'd8184)), "point outside grid")

    `BIU_ASSERT(a_out_hold, (o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_value) && $stable(o_out_row) && $stable(o_out_col) && $stable(o_last_of_run)), "stalled item changed")

    `BIU_ASSERT_ALWAYS(a_reset_idle, (!i_rst_n |=> !o_out_valid), "output valid after reset")

endmodule

bind bilinear_integer_upscaler biu_checker u_biu_checker (.*);
`default_nettype wire
